@@ design/tss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread slot scheduler package
// Shared codes, widths and the result word type of the thread slot scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int FIELD_W       = 4;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_EXIT   = 2'd2,
    OP_JOIN   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNING  = 2'd1,
    SLOT_RUNNABLE = 2'd2
  } slot_state_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] result_slot;
    logic               switched;
    logic               target_done;
    logic [FIELD_W-1:0] parent_out;
  } result_t;

endpackage
`default_nettype wire

@@ design/tss_slot_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread slot table
// Slot state and parent memories with one registered read port, one write
// port and a valid bit per entry standing in for the reset contents.
// ----------------------------------------------------------------------------
module tss_slot_table
  import tss_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(SLOTS)-1:0]   rd_addr,
  input  wire logic                       wr_state_en,
  input  wire logic                       wr_par_en,
  input  wire logic [$clog2(SLOTS)-1:0]   wr_addr,
  input  wire slot_state_t                wr_state,
  input  wire logic [FIELD_W-1:0]         wr_par,
  output slot_state_t                     rd_state,
  output logic [FIELD_W-1:0]              rd_par
);

  logic [1:0]         state_mem [SLOTS];
  logic [FIELD_W-1:0] par_mem   [SLOTS];
  logic [SLOTS-1:0]   state_vld;
  logic [SLOTS-1:0]   par_vld;
  logic [1:0]         state_q;
  logic [FIELD_W-1:0] par_q;
  logic               state_hit;
  logic               par_hit;
  logic               addr_zero;

  always_ff @(posedge clk) begin
    if (wr_state_en) begin
      state_mem[wr_addr] <= wr_state;
    end
    if (wr_par_en) begin
      par_mem[wr_addr] <= wr_par;
    end
    if (rd_en) begin
      state_q <= state_mem[rd_addr];
      par_q   <= par_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_vld <= '0;
      par_vld   <= '0;
      state_hit <= 1'b0;
      par_hit   <= 1'b0;
      addr_zero <= 1'b0;
    end else begin
      if (wr_state_en) begin
        state_vld[wr_addr] <= 1'b1;
      end
      if (wr_par_en) begin
        par_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        state_hit <= state_vld[rd_addr];
        par_hit   <= par_vld[rd_addr];
        addr_zero <= (rd_addr == '0);
      end
    end
  end

  // An entry never written reads as its reset value: slot zero running, any other slot free, with a zero parent.
  always_comb begin
    if (state_hit) begin
      rd_state = slot_state_t'(state_q);
    end else if (addr_zero) begin
      rd_state = SLOT_RUNNING;
    end else begin
      rd_state = SLOT_FREE;
    end
    rd_par = par_hit ? par_q : '0;
  end

endmodule
`default_nettype wire

@@ design/tss_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread slot scheduler sequencer
// Walks the slot table one entry a cycle through a single match unit, then
// applies the table updates and forms the result word.
// ----------------------------------------------------------------------------
module tss_seq
  import tss_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_fire,
  input  wire logic [1:0]                 opcode,
  input  wire logic [FIELD_W-1:0]         target_slot,
  input  wire logic                       res_ready,
  input  wire slot_state_t                rd_state,
  input  wire logic [FIELD_W-1:0]         rd_par,
  output logic                            idle,
  output logic                            res_valid,
  output result_t                         res,
  output logic                            rd_en,
  output logic [$clog2(SLOTS)-1:0]        rd_addr,
  output logic                            wr_state_en,
  output logic                            wr_par_en,
  output logic [$clog2(SLOTS)-1:0]        wr_addr,
  output slot_state_t                     wr_state,
  output logic [FIELD_W-1:0]              wr_par
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_JOIN_RD  = 7'b0000100,
    S_JOIN_CHK = 7'b0001000,
    S_WR_A     = 7'b0010000,
    S_WR_B     = 7'b0100000,
    S_RESP     = 7'b1000000
  } fsm_t;

  fsm_t              state;
  opcode_t           op;
  logic [SLOT_W-1:0] tgt;
  logic [SLOT_W-1:0] running;
  logic [CNT_W-1:0]  issue;
  logic              chk_vld;
  logic [SLOT_W-1:0] chk_idx;
  logic              found;
  logic [SLOT_W-1:0] nxt;
  slot_state_t       want;
  logic              hit;
  logic              last;
  logic              issuing;

  // The shared match unit: one table entry compared per cycle.
  always_comb begin
    want    = (op == OP_CREATE) ? SLOT_FREE : SLOT_RUNNABLE;
    hit     = chk_vld && (rd_state == want) &&
              !((op != OP_CREATE) && (chk_idx == running));
    last    = chk_vld && (chk_idx == SLOT_W'(SLOTS - 1));
    issuing = (state == S_SCAN) && (issue < CNT_W'(SLOTS));
  end

  always_comb begin
    idle      = (state == S_IDLE);
    res_valid = (state == S_RESP);
    rd_en     = issuing || (state == S_JOIN_RD);
    rd_addr   = (state == S_JOIN_RD) ? tgt : issue[SLOT_W-1:0];
    wr_state_en = 1'b0;
    wr_par_en   = 1'b0;
    wr_addr     = running;
    wr_state    = SLOT_RUNNING;
    wr_par      = FIELD_W'(running);
    case (state)
      S_WR_A: begin
        wr_state_en = 1'b1;
        case (op)
          OP_CREATE: begin
            wr_par_en = 1'b1;
            wr_addr   = nxt;
            wr_state  = SLOT_RUNNABLE;
          end
          OP_YIELD: begin
            wr_state = found ? SLOT_RUNNABLE : SLOT_RUNNING;
          end
          default: begin
            wr_state = SLOT_FREE;
          end
        endcase
      end
      S_WR_B: begin
        wr_state_en = 1'b1;
        wr_addr     = nxt;
        wr_state    = SLOT_RUNNING;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      running <= '0;
      chk_vld <= 1'b0;
      issue   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op      <= opcode_t'(opcode);
            tgt     <= SLOT_W'(target_slot);
            issue   <= '0;
            chk_vld <= 1'b0;
            if (opcode_t'(opcode) != OP_JOIN) begin
              state <= S_SCAN;
            end else if (32'(target_slot) < SLOTS) begin
              state <= S_JOIN_RD;
            end else begin
              res   <= '{STATUS_OK, FIELD_W'(running), 1'b0, 1'b1, '0};
              state <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          chk_vld <= issuing;
          chk_idx <= issue[SLOT_W-1:0];
          if (issuing) begin
            issue <= issue + CNT_W'(1);
          end
          if (hit) begin
            found   <= 1'b1;
            nxt     <= chk_idx;
            state   <= S_WR_A;
            if (op == OP_CREATE) begin
              res <= '{STATUS_OK, FIELD_W'(chk_idx), 1'b0, 1'b0, FIELD_W'(running)};
            end else begin
              res <= '{STATUS_OK, FIELD_W'(chk_idx), 1'b1, 1'b0, '0};
            end
          end else if (last) begin
            found <= 1'b0;
            case (op)
              OP_CREATE: begin
                res   <= '{STATUS_FULL, FIELD_W'(running), 1'b0, 1'b0, '0};
                state <= S_RESP;
              end
              OP_YIELD: begin
                res   <= '{STATUS_OK, FIELD_W'(running), 1'b0, 1'b0, '0};
                state <= S_WR_A;
              end
              default: begin
                res   <= '{STATUS_NONE, FIELD_W'(running), 1'b0, 1'b0, '0};
                state <= S_WR_A;
              end
            endcase
          end
        end
        S_JOIN_RD: begin
          state <= S_JOIN_CHK;
        end
        S_JOIN_CHK: begin
          res   <= '{STATUS_OK, FIELD_W'(running), 1'b0, (rd_state == SLOT_FREE), rd_par};
          state <= S_RESP;
        end
        S_WR_A: begin
          if (found && (op != OP_CREATE)) begin
            state <= S_WR_B;
          end else begin
            state <= S_RESP;
          end
        end
        S_WR_B: begin
          running <= nxt;
          state   <= S_RESP;
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/thread_slot_scheduler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread slot scheduler
// Fixed-priority scheduler over a table of thread slots: create, yield, exit
// and join operations, one result word for every input word.
//
// The input channel carries opcode and target_slot; the output channel
// carries status, result_slot, switched, target_done and parent_out. Both
// use valid and stall, and a word moves when valid is high and stall low.
// Create, yield and exit walk the slot table one entry a cycle through a
// single match unit, then, but for a create on a full table, write the
// table back in S_WR_A and, when the running slot changes, in S_WR_B; a
// result is ready sooner when a matching slot sits low in the table. A
// join query reads one entry; a target beyond the table reads none. One
// word is in work at a time, and in_stall stays high until its result
// has been loaded into the output register, so the next word can be taken
// while that result waits. When the receiver stalls, the result holds in
// the output register and the block stalls at most one further word
// behind it. Reset makes slot zero running, frees the others and empties
// the output register; the block takes a word in the first cycle after
// reset.
// ----------------------------------------------------------------------------
module thread_slot_scheduler_top
  import tss_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         opcode,
  input  wire logic [FIELD_W-1:0] target_slot,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [FIELD_W-1:0]      result_slot,
  output logic                    switched,
  output logic                    target_done,
  output logic [FIELD_W-1:0]      parent_out
);

  localparam int SLOT_W = $clog2(SLOTS);

  logic              idle;
  logic              in_fire;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           out_word;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_state_en;
  logic              wr_par_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_state_t       wr_state;
  logic [FIELD_W-1:0] wr_par;
  slot_state_t       rd_state;
  logic [FIELD_W-1:0] rd_par;

  assign in_stall  = !idle;
  assign in_fire   = in_valid && idle;
  assign res_ready = !out_valid || !out_stall;

  tss_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .opcode      (opcode),
    .target_slot (target_slot),
    .res_ready   (res_ready),
    .rd_state    (rd_state),
    .rd_par      (rd_par),
    .idle        (idle),
    .res_valid   (res_valid),
    .res         (res),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_state_en (wr_state_en),
    .wr_par_en   (wr_par_en),
    .wr_addr     (wr_addr),
    .wr_state    (wr_state),
    .wr_par      (wr_par)
  );

  tss_slot_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_state_en (wr_state_en),
    .wr_par_en   (wr_par_en),
    .wr_addr     (wr_addr),
    .wr_state    (wr_state),
    .wr_par      (wr_par),
    .rd_state    (rd_state),
    .rd_par      (rd_par)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign status      = out_word.status;
  assign result_slot = out_word.result_slot;
  assign switched    = out_word.switched;
  assign target_done = out_word.target_done;
  assign parent_out  = out_word.parent_out;

endmodule
`default_nettype wire

@@ design/tss_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread slot scheduler checker
// Port-level properties of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tss_checker
  import tss_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [1:0]         opcode,
  input wire logic [FIELD_W-1:0] target_slot,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         status,
  input wire logic [FIELD_W-1:0] result_slot,
  input wire logic               switched,
  input wire logic               target_done,
  input wire logic [FIELD_W-1:0] parent_out
);

  // Only one word is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after a word was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) &&
      $stable(result_slot) && $stable(switched) && $stable(target_done) &&
      $stable(parent_out)))
    else $error("stalled result word changed");

  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && switched) |-> (status == STATUS_OK && !target_done))
    else $error("switch reported with a failing status");

  a_full_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_FULL) |->
      (!switched && !target_done && parent_out == '0))
    else $error("full table result carries stray fields");

endmodule

bind thread_slot_scheduler_top tss_checker u_tss_checker (.*);
`default_nettype wire
